FILE: design/hnrt_pkg.sv
// Shared types, constants and helper functions for the held note range tracker.
`timescale 1ns / 1ps

package hnrt_pkg;

  localparam int NOTE_W        = 7;
  localparam int BYTE_W        = 8;
  localparam int BIT_IX_W      = 3;
  localparam int BYTE_IX_W     = 4;
  localparam int COUNT_W       = 8;
  localparam int MAP_BYTES_DEF = 16;

  localparam logic [NOTE_W-1:0]  NOTE_MAX  = 7'd127;
  localparam logic [NOTE_W-1:0]  NOTE_MIN  = 7'd0;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

  typedef enum logic [1:0] {
    CMD_TRIGGER = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_ALL_OFF = 2'd2,
    CMD_UNUSED  = 2'd3
  } command_t;

  typedef struct packed {
    logic clear;
    logic wr_en;
  } map_ctrl_t;

  function automatic logic [BIT_IX_W-1:0] msb_index(input logic [BYTE_W-1:0] v);
    logic [BIT_IX_W-1:0] ix;
    ix = '0;
    for (int k = 0; k < BYTE_W; k++) begin
      if (v[k]) begin
        ix = BIT_IX_W'(k);
      end
    end
    return ix;
  endfunction

  function automatic logic [BIT_IX_W-1:0] lsb_index(input logic [BYTE_W-1:0] v);
    logic [BIT_IX_W-1:0] ix;
    ix = '0;
    for (int k = BYTE_W - 1; k >= 0; k--) begin
      if (v[k]) begin
        ix = BIT_IX_W'(k);
      end
    end
    return ix;
  endfunction

endpackage

FILE: design/hnrt_map.sv
// Held note bit map: byte memory with one write port, two read ports and per-byte valid bits.
`timescale 1ns / 1ps

module hnrt_map import hnrt_pkg::*; #(
  parameter int MAP_BYTES = MAP_BYTES_DEF,
  localparam int IDX_W = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  map_ctrl_t         ctrl,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic [IDX_W-1:0]  rd_addr_a,
  input  logic [IDX_W-1:0]  rd_addr_b,
  output logic [BYTE_W-1:0] rd_data_a,
  output logic [BYTE_W-1:0] rd_data_b
);

  logic [BYTE_W-1:0]    mem [MAP_BYTES];
  logic [MAP_BYTES-1:0] valid;
  logic [BYTE_W-1:0]    q_a;
  logic [BYTE_W-1:0]    q_b;
  logic                 valid_a;
  logic                 valid_b;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    q_a     <= mem[rd_addr_a];
    q_b     <= mem[rd_addr_b];
    valid_a <= valid[rd_addr_a];
    valid_b <= valid[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      valid <= '0;
    end else if (ctrl.wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  assign rd_data_a = valid_a ? q_a : '0;
  assign rd_data_b = valid_b ? q_b : '0;

endmodule

FILE: design/held_note_range_tracker.sv
// Top level of the held note range tracker: command sequencer, scan engine and result register.
`timescale 1ns / 1ps

// The tracker keeps the held notes as a byte map in a small memory with two read ports.
// A trigger passes through the read-modify-write and output states, all notes off and the
// unused command go straight to the output state, and a release that reaches an extreme
// rescans the map one byte per cycle from both ends at once. Reset and all notes off clear
// the map at once through per-byte valid bits. A new command is taken while an earlier
// result still waits in the output register.
module held_note_range_tracker import hnrt_pkg::*; #(
  parameter int MAP_BYTES = MAP_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic [1:0]         command,
  input  logic [NOTE_W-1:0]  note,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [NOTE_W-1:0]  highest_note,
  output logic [NOTE_W-1:0]  lowest_note,
  output logic [COUNT_W-1:0] held_count,
  output logic [COUNT_W-1:0] previous_count
);

  localparam int IDX_W = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int CNT_W = $clog2(MAP_BYTES + 1);
  localparam logic [CNT_W-1:0]     LAST_STEP = CNT_W'(MAP_BYTES - 1);
  localparam logic [CNT_W-1:0]     NUM_STEPS = CNT_W'(MAP_BYTES);
  localparam logic [BYTE_IX_W:0]   MAP_LIMIT = (BYTE_IX_W + 1)'(MAP_BYTES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RMW,
    ST_SCAN,
    ST_OUT
  } state_t;

  state_t               state;
  logic [NOTE_W-1:0]    top_note;
  logic [NOTE_W-1:0]    bottom_note;
  logic [COUNT_W-1:0]   count_now;
  logic [COUNT_W-1:0]   count_before;
  command_t             cur_cmd;
  logic [NOTE_W-1:0]    cur_note;
  logic                 in_map;
  logic                 top_done;
  logic                 bot_done;
  logic [CNT_W-1:0]     issue_k;
  logic [CNT_W-1:0]     chk_k;
  logic                 chk_valid;

  map_ctrl_t            map_ctrl;
  logic [IDX_W-1:0]     rd_addr_a;
  logic [IDX_W-1:0]     rd_addr_b;
  logic [BYTE_W-1:0]    rd_data_a;
  logic [BYTE_W-1:0]    rd_data_b;
  logic [BYTE_W-1:0]    wr_data;
  logic [BYTE_W-1:0]    bit_mask;
  logic [CNT_W-1:0]     top_step;
  logic [CNT_W-1:0]     chk_top_step;
  logic                 accept;
  logic                 out_free;
  logic                 top_after;
  logic                 bot_after;
  command_t             in_cmd;

  assign accept    = cmd_valid && !cmd_stall;
  assign cmd_stall = (state != ST_IDLE);
  assign out_free  = !result_valid || !result_stall;
  assign in_cmd    = command_t'(command);

  assign bit_mask = BYTE_W'(1) << cur_note[BIT_IX_W-1:0];
  assign wr_data  = (cur_cmd == CMD_TRIGGER) ? (rd_data_a | bit_mask) : (rd_data_a & ~bit_mask);

  assign top_step     = LAST_STEP - issue_k;
  assign chk_top_step = LAST_STEP - chk_k;

  always_comb begin
    map_ctrl.clear = accept && (in_cmd == CMD_ALL_OFF);
    map_ctrl.wr_en = (state == ST_RMW) && in_map;
    rd_addr_a      = (state == ST_SCAN) ? top_step[IDX_W-1:0] : note[IDX_W+BIT_IX_W-1:BIT_IX_W];
    rd_addr_b      = issue_k[IDX_W-1:0];
  end

  assign top_after = top_done || (rd_data_a != '0);
  assign bot_after = bot_done || (rd_data_b != '0);

  hnrt_map #(
    .MAP_BYTES (MAP_BYTES)
  ) u_map (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (map_ctrl),
    .wr_addr   (cur_note[IDX_W+BIT_IX_W-1:BIT_IX_W]),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      top_note     <= NOTE_MIN;
      bottom_note  <= NOTE_MAX;
      count_now    <= '0;
      count_before <= '0;
      result_valid <= 1'b0;
      chk_valid    <= 1'b0;
      top_done     <= 1'b1;
      bot_done     <= 1'b1;
      issue_k      <= '0;
      chk_k        <= '0;
    end else begin
      if (result_valid && !result_stall && state != ST_OUT) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cur_cmd  <= in_cmd;
            cur_note <= note;
            in_map   <= ({1'b0, note[NOTE_W-1:BIT_IX_W]} < MAP_LIMIT);
            case (in_cmd)
              CMD_TRIGGER: begin
                if (count_now == '0 || note > top_note) begin
                  top_note <= note;
                end
                if (count_now == '0 || note < bottom_note) begin
                  bottom_note <= note;
                end
                count_before <= count_now;
                if (count_now != COUNT_MAX) begin
                  count_now <= count_now + COUNT_W'(1);
                end
                state <= ST_RMW;
              end
              CMD_RELEASE: begin
                count_before <= count_now;
                if (count_now != '0) begin
                  count_now <= count_now - COUNT_W'(1);
                end
                top_done <= !(note >= top_note);
                bot_done <= !(note <= bottom_note);
                state    <= ST_RMW;
              end
              CMD_ALL_OFF: begin
                top_note     <= NOTE_MIN;
                bottom_note  <= NOTE_MAX;
                count_now    <= '0;
                count_before <= '0;
                state        <= ST_OUT;
              end
              default: begin
                state <= ST_OUT;
              end
            endcase
          end
        end
        ST_RMW: begin
          issue_k   <= '0;
          chk_valid <= 1'b0;
          if (cur_cmd == CMD_RELEASE && !(top_done && bot_done)) begin
            state <= ST_SCAN;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_SCAN: begin
          if (chk_valid && ((top_after && bot_after) || chk_k == LAST_STEP)) begin
            chk_valid <= 1'b0;
            state     <= ST_OUT;
          end else if (issue_k < NUM_STEPS) begin
            chk_k     <= issue_k;
            chk_valid <= 1'b1;
            issue_k   <= issue_k + CNT_W'(1);
          end else begin
            chk_valid <= 1'b0;
          end
          if (chk_valid) begin
            if (!top_done && rd_data_a != '0) begin
              top_note <= {BYTE_IX_W'(chk_top_step[IDX_W-1:0]), msb_index(rd_data_a)};
            end
            if (!bot_done && rd_data_b != '0) begin
              bottom_note <= {BYTE_IX_W'(chk_k[IDX_W-1:0]), lsb_index(rd_data_b)};
            end
            top_done <= top_after;
            bot_done <= bot_after;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            result_valid   <= 1'b1;
            highest_note   <= top_note;
            lowest_note    <= bottom_note;
            held_count     <= count_now;
            previous_count <= count_before;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_all_off_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && in_cmd == CMD_ALL_OFF) |=>
      (count_now == '0 && top_note == NOTE_MIN && bottom_note == NOTE_MAX))
    else $error("All notes off did not restore the cleared state.");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_OUT))
    else $error("Result appeared without passing through the output state.");

  a_check_in_scan: assert property (@(posedge clk) disable iff (rst)
    chk_valid |-> (state == ST_SCAN))
    else $error("Scan data check pending outside of a scan.");

  a_count_on_transfer: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE && !$past(rst)) |=> $stable(count_now) || $past(state == ST_IDLE))
    else $error("Held count changed without a command transfer.");

endmodule

FILE: test/held_note_range_tracker_tb.sv
// Self-checking testbench for the held note range tracker: directed and random note events.
`timescale 1ns / 1ps

module held_note_range_tracker_tb;
  import hnrt_pkg::*;

  typedef struct {
    command_t          op;
    logic [NOTE_W-1:0] key;
    bit                drain;
  } note_event_t;

  typedef struct {
    logic [NOTE_W-1:0]  top;
    logic [NOTE_W-1:0]  bottom;
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] prior;
  } range_report_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT     = 230;
  localparam int CALM_FROM   = 100;
  localparam int CALM_TO     = 180;
  localparam int SETTLE      = 40;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cmd_valid = 1'b0;
  logic               cmd_stall;
  logic [1:0]         command = CMD_TRIGGER;
  logic [NOTE_W-1:0]  note = NOTE_MIN;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [NOTE_W-1:0]  highest_note;
  logic [NOTE_W-1:0]  lowest_note;
  logic [COUNT_W-1:0] held_count;
  logic [COUNT_W-1:0] previous_count;

  note_event_t   note_events[$];
  range_report_t range_reports[$];
  int            held_pool[$];

  logic [127:0]       notes_down;
  logic [COUNT_W-1:0] down_count;
  logic [COUNT_W-1:0] down_count_prior;
  logic [NOTE_W-1:0]  top_held;
  logic [NOTE_W-1:0]  bottom_held;

  bit cmd_taken = 1'b0;
  int taken_total = 0;
  int errors = 0;
  int cycle_count = 0;

  held_note_range_tracker u_dut (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd_stall      (cmd_stall),
    .command        (command),
    .note           (note),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .highest_note   (highest_note),
    .lowest_note    (lowest_note),
    .held_count     (held_count),
    .previous_count (previous_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit calm_window();
    return taken_total >= CALM_FROM && taken_total < CALM_TO;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    errors++;
    if (errors <= 100) begin
      $display("%0t: %s got %0d, want %0d", $realtime, field, got, want);
    end
  endtask

  task automatic clear_tracker();
    notes_down       = '0;
    down_count       = '0;
    down_count_prior = '0;
    top_held         = NOTE_MIN;
    bottom_held      = NOTE_MAX;
  endtask

  task automatic track_note_event(input command_t op, input logic [NOTE_W-1:0] key);
    range_report_t r;
    int            i;
    case (op)
      CMD_TRIGGER: begin
        notes_down[key] = 1'b1;
        if (down_count == 0 || key > top_held) begin
          top_held = key;
        end
        if (down_count == 0 || key < bottom_held) begin
          bottom_held = key;
        end
        down_count_prior = down_count;
        if (down_count != COUNT_MAX) begin
          down_count++;
        end
      end
      CMD_RELEASE: begin
        notes_down[key] = 1'b0;
        down_count_prior = down_count;
        if (down_count != 0) begin
          down_count--;
        end
        if (key >= top_held && notes_down != '0) begin
          i = 127;
          while (!notes_down[i]) i--;
          top_held = NOTE_W'(i);
        end
        if (key <= bottom_held && notes_down != '0) begin
          i = 0;
          while (!notes_down[i]) i++;
          bottom_held = NOTE_W'(i);
        end
      end
      CMD_ALL_OFF: begin
        clear_tracker();
      end
      default: begin
      end
    endcase
    r.top    = top_held;
    r.bottom = bottom_held;
    r.count  = down_count;
    r.prior  = down_count_prior;
    range_reports.push_back(r);
  endtask

  task automatic add_event(input command_t op, input int key);
    note_event_t e;
    e.op    = op;
    e.key   = NOTE_W'(key);
    e.drain = 1'b0;
    note_events.push_back(e);
  endtask

  task automatic add_drain();
    note_event_t e;
    e.op    = CMD_UNUSED;
    e.key   = NOTE_MIN;
    e.drain = 1'b1;
    note_events.push_back(e);
  endtask

  task automatic add_mixed(input int n);
    int roll;
    int key;
    int ix;
    for (int j = 0; j < n; j++) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        key = $urandom_range(0, 127);
        held_pool.push_back(key);
        add_event(CMD_TRIGGER, key);
      end else if (roll < 85) begin
        if (held_pool.size() > 0 && $urandom_range(0, 99) < 70) begin
          ix = $urandom_range(0, held_pool.size() - 1);
          key = held_pool[ix];
          held_pool.delete(ix);
        end else begin
          key = $urandom_range(0, 127);
        end
        add_event(CMD_RELEASE, key);
      end else if (roll < 95) begin
        held_pool.delete();
        add_event(CMD_ALL_OFF, $urandom_range(0, 127));
      end else begin
        add_event(CMD_UNUSED, $urandom_range(0, 127));
      end
    end
  endtask

  // Input and output handshakes, prediction and checking.
  always @(posedge clk) begin
    range_report_t want;
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("held_note_range_tracker: mismatch");
      $finish;
    end
    cmd_taken = !rst && cmd_valid && !cmd_stall;
    if (cmd_taken) begin
      track_note_event(command_t'(command), note);
      taken_total++;
    end
    if (!rst && result_valid && !result_stall) begin
      if (range_reports.size() == 0) begin
        report_mismatch("unexpected transfer, held_count", held_count, -1);
      end else begin
        want = range_reports.pop_front();
        if (highest_note !== want.top) begin
          report_mismatch("highest_note", highest_note, want.top);
        end
        if (lowest_note !== want.bottom) begin
          report_mismatch("lowest_note", lowest_note, want.bottom);
        end
        if (held_count !== want.count) begin
          report_mismatch("held_count", held_count, want.count);
        end
        if (previous_count !== want.prior) begin
          report_mismatch("previous_count", previous_count, want.prior);
        end
      end
    end
  end

  // Command driver.
  always @(negedge clk) begin
    note_event_t e;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_taken) begin
      if (note_events.size() > 0 && note_events[0].drain) begin
        if (range_reports.size() == 0) begin
          void'(note_events.pop_front());
        end
        cmd_valid <= 1'b0;
      end else if (note_events.size() > 0 &&
                   (calm_window() || $urandom_range(0, 99) >= 29)) begin
        e = note_events.pop_front();
        command   <= e.op;
        note      <= e.key;
        cmd_valid <= 1'b1;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // Result receiver, with one long hold-off to back the block up.
  always @(negedge clk) begin
    int hold_left;
    bit hold_done;
    if (rst) begin
      result_stall <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (!hold_done && taken_total >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (calm_window()) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(0, 99) < 29);
    end
  end

  initial begin
    int key;
    clear_tracker();

    add_event(CMD_TRIGGER, 0);
    add_event(CMD_TRIGGER, 127);
    add_event(CMD_TRIGGER, 64);
    add_event(CMD_TRIGGER, 64);
    add_event(CMD_RELEASE, 100);
    add_event(CMD_RELEASE, 127);
    add_event(CMD_RELEASE, 0);
    add_event(CMD_RELEASE, 64);
    add_event(CMD_RELEASE, 5);
    add_event(CMD_UNUSED, 127);
    add_event(CMD_TRIGGER, 85);
    add_event(CMD_TRIGGER, 42);
    add_event(CMD_RELEASE, 85);
    add_event(CMD_ALL_OFF, 127);
    add_event(CMD_RELEASE, 127);
    add_event(CMD_RELEASE, 0);
    add_event(CMD_TRIGGER, 127);
    add_event(CMD_TRIGGER, 0);
    add_event(CMD_RELEASE, 0);
    add_event(CMD_RELEASE, 127);
    add_event(CMD_ALL_OFF, 0);
    add_drain();

    add_mixed(50);

    // Enough triggers in a row to pin the count at its ceiling.
    for (int j = 0; j < 258; j++) begin
      key = $urandom_range(0, 127);
      held_pool.push_back(key);
      add_event(CMD_TRIGGER, key);
    end
    add_mixed(30);
    add_drain();
    add_mixed(40);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (note_events.size() > 0 || cmd_valid || range_reports.size() > 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
    if (range_reports.size() != 0) begin
      report_mismatch("missing transfers", 0, range_reports.size());
    end
    if (errors == 0) begin
      $display("held_note_range_tracker: match");
    end else begin
      $display("held_note_range_tracker: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
design/hnrt_pkg.sv
design/hnrt_map.sv
design/held_note_range_tracker.sv
test/held_note_range_tracker_tb.sv
